[hdl/srfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfp_pkg
// Types and constants for the serial response frame parser.
// ----------------------------------------------------------------------------
package srfp_pkg;

    localparam logic [7:0] HEAD_FIRST       = 8'h57;
    localparam logic [7:0] HEAD_SECOND      = 8'hAB;
    localparam logic [7:0] RESP_OK_BITS     = 8'h80;
    localparam logic [7:0] RESP_ERR_BITS    = 8'hC0;
    localparam logic [7:0] SUM_ERROR_STATUS = 8'hE4;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        VERDICT_SUCCESS   = 3'd0,
        VERDICT_DEV_ERROR = 3'd1,
        VERDICT_SUM_ERROR = 3'd2,
        VERDICT_BAD_CMD   = 3'd3,
        VERDICT_EMPTY     = 3'd4
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

endpackage

[hdl/serial_response_frame_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_response_frame_parser_top
// Hunts for a 0x57 0xAB header, parses address, command, length, payload and
// a sum-8 checksum; passes payload bytes out and ends with a frame summary.
// Results are registered: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the request side stalls only while the
//   result register holds a result that is not taken.
// Reset: synchronous, active low; returns to header hunt and clears the
//   expected command register.
// ----------------------------------------------------------------------------
module serial_response_frame_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_result_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_frame_address,
    output logic [7:0] o_frame_command,
    output logic [7:0] o_frame_length,
    output logic       o_checksum_ok,
    output logic [2:0] o_verdict,
    output logic [7:0] o_status_byte,
    output logic       o_last
);
    import srfp_pkg::*;

    // parser state
    t_phase     r_phase, n_phase;
    logic       r_saw, n_saw;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_len, n_len;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_first, n_first;
    logic [7:0] r_exp_cmd;

    // result register
    logic       r_out_valid, n_out_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_data, n_data;
    logic [7:0] r_res_addr, n_res_addr;
    logic [7:0] r_res_cmd, n_res_cmd;
    logic [7:0] r_res_len, n_res_len;
    logic       r_ok, n_ok;
    t_verdict   r_verdict, n_verdict;
    logic [7:0] r_status, n_status;

    logic       accept;
    logic       res_fire;
    logic [7:0] cnt_inc;
    logic       sum_match;
    logic       cmd_match;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign cnt_inc    = r_cnt + 8'd1;
    assign sum_match  = (i_rx_byte == r_sum);
    assign cmd_match  = (r_cmd == (r_exp_cmd | RESP_OK_BITS)) ||
                        (r_cmd == (r_exp_cmd | RESP_ERR_BITS));

    always_comb begin
        n_phase     = r_phase;
        n_saw       = r_saw;
        n_sum       = r_sum;
        n_addr      = r_addr;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_first     = r_first;
        res_fire    = 1'b0;
        n_kind      = KIND_PAYLOAD;
        n_data      = 8'd0;
        n_res_addr  = r_addr;
        n_res_cmd   = r_cmd;
        n_res_len   = r_len;
        n_ok        = 1'b0;
        n_verdict   = VERDICT_SUCCESS;
        n_status    = 8'd0;

        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (r_saw && (i_rx_byte == HEAD_SECOND)) begin
                        n_phase = PH_ADDR;
                        n_sum   = HEAD_FIRST + HEAD_SECOND;
                        n_saw   = 1'b0;
                    end else begin
                        n_saw   = (i_rx_byte == HEAD_FIRST);
                    end
                end
                PH_ADDR: begin
                    n_addr  = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_sum   = r_sum + i_rx_byte;
                    n_cnt   = 8'd0;
                    n_first = 8'd0;
                    n_phase = (i_rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                end
                PH_DATA: begin
                    if (r_cnt == 8'd0) begin
                        n_first = i_rx_byte;
                    end
                    n_sum    = r_sum + i_rx_byte;
                    n_cnt    = cnt_inc;
                    if (cnt_inc == r_len) begin
                        n_phase = PH_SUM;
                    end
                    res_fire = 1'b1;
                    n_data   = i_rx_byte;
                end
                PH_SUM: begin
                    res_fire = 1'b1;
                    n_kind   = KIND_SUMMARY;
                    n_ok     = sum_match;
                    n_status = (r_len != 8'd0) ? r_first : 8'd0;
                    // checksum error outranks everything else
                    if (!sum_match) begin
                        n_verdict = VERDICT_SUM_ERROR;
                        n_status  = SUM_ERROR_STATUS;
                    end else if (!cmd_match) begin
                        n_verdict = VERDICT_BAD_CMD;
                    end else if (r_len == 8'd0) begin
                        n_verdict = VERDICT_EMPTY;
                    end else if (r_first != 8'd0) begin
                        n_verdict = VERDICT_DEV_ERROR;
                    end else begin
                        n_verdict = VERDICT_SUCCESS;
                    end
                    n_phase = PH_HUNT;
                    n_saw   = 1'b0;
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_saw   = 1'b0;
                end
            endcase
        end

        // hold a result until taken, drop it once taken
        if (res_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_saw       <= 1'b0;
            r_sum       <= 8'd0;
            r_addr      <= 8'd0;
            r_cmd       <= 8'd0;
            r_len       <= 8'd0;
            r_cnt       <= 8'd0;
            r_first     <= 8'd0;
            r_exp_cmd   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_saw       <= n_saw;
            r_sum       <= n_sum;
            r_addr      <= n_addr;
            r_cmd       <= n_cmd;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_exp_cmd <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_kind     <= n_kind;
            r_data     <= n_data;
            r_res_addr <= n_res_addr;
            r_res_cmd  <= n_res_cmd;
            r_res_len  <= n_res_len;
            r_ok       <= n_ok;
            r_verdict  <= n_verdict;
            r_status   <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_data_byte     = r_data;
    assign o_frame_address = r_res_addr;
    assign o_frame_command = r_res_cmd;
    assign o_frame_length  = r_res_len;
    assign o_checksum_ok   = r_ok;
    assign o_verdict       = r_verdict;
    assign o_status_byte   = r_status;
    assign o_last          = r_kind;

endmodule

[test/tb_serial_response_frame_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_response_frame_parser_top
// Feeds byte streams of headers, frames and noise into the frame parser with
// random gaps and output stalls. A cycle-free model of the parser predicts
// the payload and summary results, which are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_serial_response_frame_parser_top;
    import srfp_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] len;
        logic       ok;
        t_verdict   verdict;
        logic [7:0] status;
        logic       last;
    } t_frame_result;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_result_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_frame_address;
    logic [7:0] o_frame_command;
    logic [7:0] o_frame_length;
    logic       o_checksum_ok;
    logic [2:0] o_verdict;
    logic [7:0] o_status_byte;
    logic       o_last;

    serial_response_frame_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_address(o_frame_address),
        .o_frame_command(o_frame_command),
        .o_frame_length (o_frame_length),
        .o_checksum_ok  (o_checksum_ok),
        .o_verdict      (o_verdict),
        .o_status_byte  (o_status_byte),
        .o_last         (o_last)
    );

    always #2 i_clk = ~i_clk;

    logic [7:0]    rx_stream[$];
    t_frame_result pending_results[$];
    int            pushed_bytes   = 0;
    int            accepted_bytes = 0;
    int            fail_count     = 0;

    // Parser model state
    logic [7:0] cmd_reg = 8'h00;
    t_phase     parse_phase = PH_HUNT;
    logic       saw_head = 1'b0;
    logic [7:0] run_sum = 8'h00;
    logic [7:0] hold_addr = 8'h00;
    logic [7:0] hold_cmd = 8'h00;
    logic [7:0] hold_len = 8'h00;
    logic [7:0] pay_count = 8'h00;
    logic [7:0] first_pay = 8'h00;

    function automatic void note_result(t_kind kind, logic [7:0] data, logic ok,
                                        t_verdict verdict, logic [7:0] status);
        t_frame_result r;
        r.kind    = kind;
        r.data    = data;
        r.addr    = hold_addr;
        r.cmd     = hold_cmd;
        r.len     = hold_len;
        r.ok      = ok;
        r.verdict = verdict;
        r.status  = status;
        r.last    = (kind == KIND_SUMMARY);
        pending_results = {pending_results, r};
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        logic       ok;
        t_verdict   verdict;
        logic [7:0] status;
        case (parse_phase)
            PH_HUNT: begin
                if (saw_head && b == HEAD_SECOND) begin
                    parse_phase = PH_ADDR;
                    run_sum     = HEAD_FIRST + HEAD_SECOND;
                    saw_head    = 1'b0;
                end else begin
                    saw_head = (b == HEAD_FIRST);
                end
            end
            PH_ADDR: begin
                hold_addr   = b;
                run_sum     = run_sum + b;
                parse_phase = PH_CMD;
            end
            PH_CMD: begin
                hold_cmd    = b;
                run_sum     = run_sum + b;
                parse_phase = PH_LEN;
            end
            PH_LEN: begin
                hold_len    = b;
                run_sum     = run_sum + b;
                pay_count   = 8'h00;
                first_pay   = 8'h00;
                parse_phase = (b == 8'h00) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                if (pay_count == 8'h00) first_pay = b;
                run_sum   = run_sum + b;
                pay_count = pay_count + 8'h01;
                if (pay_count == hold_len) parse_phase = PH_SUM;
                note_result(KIND_PAYLOAD, b, 1'b0, VERDICT_SUCCESS, 8'h00);
            end
            PH_SUM: begin
                ok     = (b == run_sum);
                status = (hold_len != 8'h00) ? first_pay : 8'h00;
                if (!ok) begin
                    verdict = VERDICT_SUM_ERROR;
                    status  = SUM_ERROR_STATUS;
                end else if (hold_cmd != (cmd_reg | RESP_OK_BITS) &&
                             hold_cmd != (cmd_reg | RESP_ERR_BITS)) begin
                    verdict = VERDICT_BAD_CMD;
                end else if (hold_len == 8'h00) begin
                    verdict = VERDICT_EMPTY;
                end else if (first_pay != 8'h00) begin
                    verdict = VERDICT_DEV_ERROR;
                end else begin
                    verdict = VERDICT_SUCCESS;
                end
                note_result(KIND_SUMMARY, 8'h00, ok, verdict, status);
                parse_phase = PH_HUNT;
                saw_head    = 1'b0;
            end
            default: begin
                parse_phase = PH_HUNT;
                saw_head    = 1'b0;
            end
        endcase
    endfunction

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Request driver
    int send_gap  = 0;
    int send_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                parse_rx_byte(i_rx_byte);
                accepted_bytes++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (rx_stream.size() > 0) begin
                    i_rx_byte  <= rx_stream.pop_front();
                    i_in_valid <= 1'b1;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(49) == 0) send_calm = $urandom_range(20, 80);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    int            stall_left = 0;
    int            stall_calm = 0;
    t_frame_result want;

    function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d data %02h",
                             $time, o_result_kind, o_data_byte);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_kind", 8'(want.kind), 8'(o_result_kind));
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("frame_address", want.addr, o_frame_address);
                    check_field("frame_command", want.cmd, o_frame_command);
                    check_field("frame_length", want.len, o_frame_length);
                    check_field("checksum_ok", 8'(want.ok), 8'(o_checksum_ok));
                    check_field("verdict", 8'(want.verdict), 8'(o_verdict));
                    check_field("status_byte", want.status, o_status_byte);
                    check_field("last", 8'(want.last), 8'(o_last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (stall_calm > 0) begin
                    stall_calm--;
                end else begin
                    stall_left = pick_gap();
                    if ($urandom_range(49) == 0) stall_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_stream = {rx_stream, b};
        pushed_bytes++;
    endtask

    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd,
                               input logic [7:0] len, input logic [7:0] first,
                               input logic [7:0] sum_flip);
        logic [7:0] sum;
        logic [7:0] pay;
        sum = HEAD_FIRST + HEAD_SECOND + addr + cmd + len;
        push_byte(HEAD_FIRST);
        push_byte(HEAD_SECOND);
        push_byte(addr);
        push_byte(cmd);
        push_byte(len);
        for (int i = 0; i < int'(len); i++) begin
            pay = (i == 0) ? first : 8'($urandom);
            sum = sum + pay;
            push_byte(pay);
        end
        push_byte(sum ^ sum_flip);
    endtask

    task automatic queue_random_frame();
        int         r;
        int         noise;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] first;
        logic [7:0] flip;
        // Noise and broken headers between frames
        if ($urandom_range(99) < 15) begin
            noise = $urandom_range(1, 4);
            for (int i = 0; i < noise; i++) begin
                push_byte(($urandom_range(2) == 0) ? HEAD_FIRST : 8'($urandom));
            end
        end
        r = $urandom_range(99);
        if (r < 40) cmd = cmd_reg | RESP_OK_BITS;
        else if (r < 70) cmd = cmd_reg | RESP_ERR_BITS;
        else cmd = 8'($urandom);
        r = $urandom_range(99);
        if (r < 15) len = 8'h00;
        else if (r < 95) len = 8'($urandom_range(1, 8));
        else len = 8'($urandom_range(9, 40));
        first = ($urandom_range(99) < 40) ? 8'h00 : 8'($urandom);
        flip  = ($urandom_range(99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
        queue_frame(8'($urandom), cmd, len, first, flip);
    endtask

    task automatic wait_idle();
        while (accepted_bytes != pushed_bytes || pending_results.size() != 0)
            @(posedge i_clk);
        // Let a byte that causes no result settle in the parser
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_expected_command(input logic [7:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        cmd_reg     = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [7:0] cmd_value, input int n_bytes,
                                    input bit with_long);
        int goal;
        set_expected_command(cmd_value);
        goal = pushed_bytes + n_bytes;
        if (with_long) queue_frame(8'($urandom), cmd_reg | RESP_OK_BITS, 8'hFF, 8'h00, 8'h00);
        while (pushed_bytes < goal) queue_random_frame();
    endtask

    int drain;

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, expected command at its reset value of zero.
        // Broken header, then a header preceded by a repeated first byte.
        push_byte(HEAD_FIRST);
        push_byte(8'h12);
        push_byte(HEAD_FIRST);
        queue_frame(8'hFF, RESP_OK_BITS, 8'h01, 8'h00, 8'h00);
        // Checksum error whose checksum byte is the first header byte; the
        // following second header byte must not open a frame.
        queue_frame(8'h00, RESP_ERR_BITS, 8'h00, 8'h00, 8'h95);
        push_byte(HEAD_SECOND);
        // Bad command wins over empty payload, then a plain empty payload
        queue_frame(8'hA5, 8'h13, 8'h00, 8'h00, 8'h00);
        queue_frame(8'h00, RESP_OK_BITS, 8'h00, 8'h00, 8'h00);

        run_random_phase(8'hFF, 100, 1'b0);
        run_random_phase(8'($urandom), 100, 1'b0);
        run_random_phase(8'h00, 100, 1'b1);
        run_random_phase(8'h3F, 100, 1'b0);
        run_random_phase(8'($urandom), 100, 1'b0);

        while (accepted_bytes != pushed_bytes) @(posedge i_clk);
        drain = 0;
        while (pending_results.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected kind %0d first",
                     $time, pending_results.size(), pending_results[0].kind);
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
